// ===== sv/cea_pkg.sv =====
// cea_pkg: shared constants, types and helper functions of the curve extent accumulator.
// Holds the Q.30 angle constants, the CORDIC arctangent table and the cardinal sweep test.
// No dependencies.
`default_nettype none

package cea_pkg;

    localparam int CORDIC_STEPS_DEFAULT = 18;
    localparam int CORDIC_MAX_STEPS     = 32;

    // item modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;
    localparam logic [1:0] MODE_ARC   = 2'd3;

    // angle constants in units of 2^-30
    localparam logic signed [33:0] TWO_PI_Q30      = 34'sd6746518852;
    localparam logic signed [33:0] PI_Q30          = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // sweep test constants in Q4.16
    localparam logic signed [21:0] TWO_PI_Q16 = 22'sd411775;
    localparam logic signed [21:0] CARD_Q16 [4] = '{
        22'sd0, 22'sd102944, 22'sd205887, 22'sd308831
    };

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // request to the box register
    typedef struct packed {
        logic clear;
        logic add;
    } box_cmd_t;

    // status of the CORDIC unit
    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // one bit per cardinal angle (0, pi/2, pi, 3pi/2): reached by the ccw sweep
    function automatic logic [3:0] card_hits(input logic signed [19:0] sa,
                                             input logic signed [19:0] ea);
        logic signed [21:0] sa_ext;
        logic signed [21:0] sweep;
        logic signed [21:0] to;
        logic [3:0]         hit;
        sa_ext = $signed({{2{sa[19]}}, sa});
        sweep  = $signed({{2{ea[19]}}, ea}) - sa_ext;
        for (int k = 0; k < 3; k++)
        begin
            if (sweep < 0)
                sweep = sweep + TWO_PI_Q16;
        end
        for (int q = 0; q < 4; q++)
        begin
            to = CARD_Q16[q] - sa_ext;
            for (int k = 0; k < 2; k++)
            begin
                if (to < 0)
                    to = to + TWO_PI_Q16;
            end
            for (int k = 0; k < 2; k++)
            begin
                if (to >= TWO_PI_Q16)
                    to = to - TWO_PI_Q16;
            end
            hit[q] = (to <= sweep);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cea_cordic.sv =====
// cea_cordic: iterative rotation-mode CORDIC giving cosine and sine of a Q4.16 angle.
// One micro-rotation per cycle through a shared shift/add unit; uses cea_pkg.
`default_nettype none

module cea_cordic #(
    parameter int STEPS = cea_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [19:0]     angle,
    output cea_pkg::cordic_stat_t  stat,
    output logic signed [31:0]     cos_val,
    output logic signed [31:0]     sin_val
);
    import cea_pkg::*;

    localparam int         NITER    = (STEPS < CORDIC_MAX_STEPS) ? STEPS : CORDIC_MAX_STEPS;
    localparam logic [4:0] LAST_IDX = 5'(NITER - 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_FOLD = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;
    localparam logic [1:0] C_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [4:0]         idx_reg, idx_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               neg_reg, neg_next;

    logic signed [33:0] z_wide;
    logic signed [33:0] z_red;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] atan_val;
    logic signed [33:0] x_neg;
    logic signed [33:0] y_neg;

    always_comb
    begin
        z_wide = $signed({angle, 14'b0});
        if (z_wide >= PI_Q30)
            z_red = z_wide - TWO_PI_Q30;
        else if (z_wide < -PI_Q30)
            z_red = z_wide + TWO_PI_Q30;
        else
            z_red = z_wide;

        dx       = y_reg >>> idx_reg;
        dy       = x_reg >>> idx_reg;
        atan_val = $signed({4'b0, ATAN_TAB[idx_reg]});

        state_next = state_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        neg_next   = neg_reg;

        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    z_next     = z_red;
                    x_next     = CORDIC_GAIN_Q30;
                    y_next     = '0;
                    state_next = C_FOLD;
                end
            end
            C_FOLD:
            begin
                // fold into [-pi/2, pi/2]; remember to negate the result
                if (z_reg > HALF_PI_Q30)
                begin
                    z_next   = z_reg - PI_Q30;
                    neg_next = 1'b1;
                end
                else if (z_reg < -HALF_PI_Q30)
                begin
                    z_next   = z_reg + PI_Q30;
                    neg_next = 1'b1;
                end
                else
                begin
                    neg_next = 1'b0;
                end
                idx_next   = '0;
                state_next = C_ITER;
            end
            C_ITER:
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_val;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_val;
                end
                idx_next = idx_reg + 5'd1;
                if (idx_reg == LAST_IDX)
                    state_next = C_DONE;
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign x_neg     = -x_reg;
    assign y_neg     = -y_reg;
    assign cos_val   = neg_reg ? x_neg[31:0] : x_reg[31:0];
    assign sin_val   = neg_reg ? y_neg[31:0] : y_reg[31:0];
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_DONE);

endmodule

`default_nettype wire

// ===== sv/cea_box.sv =====
// cea_box: bounding box register with its grow and clear logic.
// Uses cea_pkg for the request type.
`default_nettype none

module cea_box (
    input  logic                clk,
    input  logic                rst_n,
    input  cea_pkg::box_cmd_t   cmd,
    input  logic signed [31:0]  x,
    input  logic signed [31:0]  y,
    output logic signed [31:0]  low_x,
    output logic signed [31:0]  low_y,
    output logic signed [31:0]  high_x,
    output logic signed [31:0]  high_y,
    output logic                empty
);
    import cea_pkg::*;

    logic signed [31:0] low_x_reg, low_x_next;
    logic signed [31:0] low_y_reg, low_y_next;
    logic signed [31:0] high_x_reg, high_x_next;
    logic signed [31:0] high_y_reg, high_y_next;
    logic               empty_reg, empty_next;

    always_comb
    begin
        low_x_next  = low_x_reg;
        low_y_next  = low_y_reg;
        high_x_next = high_x_reg;
        high_y_next = high_y_reg;
        empty_next  = empty_reg;
        priority if (cmd.clear)
        begin
            low_x_next  = '0;
            low_y_next  = '0;
            high_x_next = '0;
            high_y_next = '0;
            empty_next  = 1'b1;
        end
        else if (cmd.add && empty_reg)
        begin
            // first point: seed all four bounds
            low_x_next  = x;
            high_x_next = x;
            low_y_next  = y;
            high_y_next = y;
            empty_next  = 1'b0;
        end
        else if (cmd.add)
        begin
            if (x < low_x_reg)
                low_x_next = x;
            if (y < low_y_reg)
                low_y_next = y;
            if (x > high_x_reg)
                high_x_next = x;
            if (y > high_y_reg)
                high_y_next = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            high_x_reg <= '0;
            high_y_reg <= '0;
            empty_reg  <= 1'b1;
        end
        else
        begin
            low_x_reg  <= low_x_next;
            low_y_reg  <= low_y_next;
            high_x_reg <= high_x_next;
            high_y_reg <= high_y_next;
            empty_reg  <= empty_next;
        end
    end

    assign low_x  = low_x_reg;
    assign low_y  = low_y_reg;
    assign high_x = high_x_reg;
    assign high_y = high_y_reg;
    assign empty  = empty_reg;

endmodule

`default_nettype wire

// ===== sv/curve_extent_accumulator.sv =====
// curve_extent_accumulator: top level, sequencer, shared multiplier and result register.
// Instantiates cea_cordic and cea_box; uses cea_pkg.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------------------
//  in      | in_valid/in_ready  | mode, point_a_x/y, point_b_x/y, radius, start/end_angle,
//          |                    | full_circle
//  out     | out_valid/out_ready| box_min_x/y, box_max_x/y, box_empty (one per input item)
//
// Each item passes through the sequencer: clear and point items make one box request,
// line items two, and arcs run the CORDIC loop (min(CORDIC_STEPS, 32) micro-rotations)
// once per arc end, then add both ends and each cardinal point that the sweep reaches.
// Reset (rst_n low, asynchronous) empties the box, zeroes its bounds and drops out_valid.
// in_ready is high only while the sequencer is idle; a finished result waits in the output
// register, so the next item may transfer while out_ready is low. The sequencer stalls at
// the end of an item only when the previous result has still not been taken.
`default_nettype none

module curve_extent_accumulator #(
    parameter int CORDIC_STEPS = cea_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] point_a_x,
    input  logic signed [31:0] point_a_y,
    input  logic signed [31:0] point_b_x,
    input  logic signed [31:0] point_b_y,
    input  logic [30:0]        radius,
    input  logic signed [19:0] start_angle,
    input  logic signed [19:0] end_angle,
    input  logic               full_circle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] box_min_x,
    output logic signed [31:0] box_min_y,
    output logic signed [31:0] box_max_x,
    output logic signed [31:0] box_max_y,
    output logic               box_empty
);
    import cea_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_POINT     = 4'd1;   // clear, or add point A
    localparam logic [3:0] S_POINT_B   = 4'd2;   // add line end
    localparam logic [3:0] S_ARC_START = 4'd3;   // launch CORDIC on one arc end
    localparam logic [3:0] S_ARC_WAIT  = 4'd4;
    localparam logic [3:0] S_MUL_X     = 4'd5;   // radius * cos
    localparam logic [3:0] S_MUL_Y     = 4'd6;   // place x, radius * sin
    localparam logic [3:0] S_SAT_Y     = 4'd7;   // place y
    localparam logic [3:0] S_ARC_GROW  = 4'd8;
    localparam logic [3:0] S_CARD      = 4'd9;   // form one cardinal point if reached
    localparam logic [3:0] S_CARD_GROW = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;  // hand box to the output register

    localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;

    logic [3:0]         state_reg, state_next;
    logic               side_reg, side_next;      // 0 start angle, 1 end angle
    logic [1:0]         q_reg, q_next;
    logic [3:0]         hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;

    // captured item
    logic [1:0]         mode_reg;
    logic signed [31:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [30:0]        r_reg;
    logic signed [19:0] sa_reg, ea_reg;
    logic               full_reg;

    // arithmetic registers
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;

    // output register
    logic signed [31:0] o_min_x_reg, o_min_y_reg, o_max_x_reg, o_max_y_reg;
    logic               o_empty_reg;

    logic               accept;
    logic               load_out;
    logic               cordic_start;
    logic signed [19:0] cordic_angle;
    cordic_stat_t       cstat;
    logic signed [31:0] cos_val, sin_val;
    logic signed [31:0] trig;
    logic signed [63:0] mul_out;
    logic signed [63:0] rounded;
    logic signed [33:0] offset;
    logic signed [31:0] centre;
    logic signed [35:0] placed_sum;
    logic signed [35:0] r_ext, ax_ext, ay_ext;
    logic signed [31:0] card_x, card_y;

    box_cmd_t           bcmd;
    logic signed [31:0] grow_x, grow_y;
    logic signed [31:0] low_x, low_y, high_x, high_y;
    logic               is_empty;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    cea_cordic #(
        .STEPS   (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .stat    (cstat),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    cea_box u_box (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (bcmd),
        .x      (grow_x),
        .y      (grow_y),
        .low_x  (low_x),
        .low_y  (low_y),
        .high_x (high_x),
        .high_y (high_y),
        .empty  (is_empty)
    );

    // shared multiplier and rounding: offset = floor((r * trig + 2^29) / 2^30)
    always_comb
    begin
        trig       = (state_reg == S_MUL_Y) ? sin_val : cos_val;
        mul_out    = $signed({1'b0, r_reg}) * trig;
        rounded    = prod_reg + ROUND_HALF;
        offset     = rounded[63:30];
        centre     = (state_reg == S_SAT_Y) ? ay_reg : ax_reg;
        placed_sum = $signed({{4{centre[31]}}, centre}) + $signed({{2{offset[33]}}, offset});
    end

    // cardinal point for the current quadrant index
    always_comb
    begin
        r_ext  = $signed({5'b0, r_reg});
        ax_ext = $signed({{4{ax_reg[31]}}, ax_reg});
        ay_ext = $signed({{4{ay_reg[31]}}, ay_reg});
        unique case (q_reg)
            2'd0:
            begin
                card_x = sat32(ax_ext + r_ext);
                card_y = ay_reg;
            end
            2'd1:
            begin
                card_x = ax_reg;
                card_y = sat32(ay_ext + r_ext);
            end
            2'd2:
            begin
                card_x = sat32(ax_ext - r_ext);
                card_y = ay_reg;
            end
            2'd3:
            begin
                card_x = ax_reg;
                card_y = sat32(ay_ext - r_ext);
            end
        endcase
    end

    // box requests
    always_comb
    begin
        bcmd.clear = (state_reg == S_POINT) && (mode_reg == MODE_CLEAR);
        bcmd.add   = ((state_reg == S_POINT) && (mode_reg != MODE_CLEAR)) ||
                     (state_reg == S_POINT_B) || (state_reg == S_ARC_GROW) ||
                     (state_reg == S_CARD_GROW);
        unique case (state_reg)
            S_POINT:
            begin
                grow_x = ax_reg;
                grow_y = ay_reg;
            end
            S_POINT_B:
            begin
                grow_x = bx_reg;
                grow_y = by_reg;
            end
            default:
            begin
                grow_x = px_reg;
                grow_y = py_reg;
            end
        endcase
    end

    assign cordic_start = (state_reg == S_ARC_START);
    assign cordic_angle = side_reg ? ea_reg : sa_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        q_next         = q_reg;
        hit_next       = hit_reg;
        prod_next      = prod_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    side_next  = 1'b0;
                    state_next = (mode == MODE_ARC) ? S_ARC_START : S_POINT;
                end
            end
            S_POINT:
            begin
                state_next = (mode_reg == MODE_LINE) ? S_POINT_B : S_DONE;
            end
            S_POINT_B:
            begin
                state_next = S_DONE;
            end
            S_ARC_START:
            begin
                if (!side_reg)
                    hit_next = full_reg ? 4'hF : card_hits(sa_reg, ea_reg);
                state_next = S_ARC_WAIT;
            end
            S_ARC_WAIT:
            begin
                if (cstat.done)
                    state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                prod_next  = mul_out;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                px_next    = sat32(placed_sum);
                prod_next  = mul_out;
                state_next = S_SAT_Y;
            end
            S_SAT_Y:
            begin
                py_next    = sat32(placed_sum);
                state_next = S_ARC_GROW;
            end
            S_ARC_GROW:
            begin
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = S_ARC_START;
                end
                else
                begin
                    q_next     = 2'd0;
                    state_next = S_CARD;
                end
            end
            S_CARD:
            begin
                // skip cardinal points the sweep misses
                if (hit_reg[q_reg])
                begin
                    px_next    = card_x;
                    py_next    = card_y;
                    state_next = S_CARD_GROW;
                end
                else if (q_reg == 2'd3)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    q_next = q_reg + 2'd1;
                end
            end
            S_CARD_GROW:
            begin
                if (q_reg == 2'd3)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    q_next     = q_reg + 2'd1;
                    state_next = S_CARD;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= 1'b0;
            q_reg         <= '0;
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            q_reg         <= q_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the item on its transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            ax_reg   <= point_a_x;
            ay_reg   <= point_a_y;
            bx_reg   <= point_b_x;
            by_reg   <= point_b_y;
            r_reg    <= radius;
            sa_reg   <= start_angle;
            ea_reg   <= end_angle;
            full_reg <= full_circle;
        end
        prod_reg <= prod_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_min_x_reg <= low_x;
            o_min_y_reg <= low_y;
            o_max_x_reg <= high_x;
            o_max_y_reg <= high_y;
            o_empty_reg <= is_empty;
        end
    end

    assign out_valid = out_valid_reg;
    assign box_min_x = o_min_x_reg;
    assign box_min_y = o_min_y_reg;
    assign box_max_x = o_max_x_reg;
    assign box_max_y = o_max_y_reg;
    assign box_empty = o_empty_reg;

    a_idle_cordic_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cstat.busy)
        else $error("CORDIC busy while the sequencer is idle");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        cstat.done |-> (state_reg == S_ARC_WAIT))
        else $error("CORDIC finished outside the wait state");

    a_box_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(bcmd.clear && bcmd.add))
        else $error("box clear and add requested together");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !box_empty) |-> ((box_min_x <= box_max_x) && (box_min_y <= box_max_y)))
        else $error("presented box has a lower bound above its upper bound");

endmodule

`default_nettype wire
